// ===== rtl/snooping_msi_direct_mapped_cache_assert.svh =====
// Assertion macros for the snooping MSI cache.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SNOOPING_MSI_DIRECT_MAPPED_CACHE_ASSERT_SVH
`define SNOOPING_MSI_DIRECT_MAPPED_CACHE_ASSERT_SVH

// same-cycle implication
`define SMDMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smdmc check failed");

// next-cycle implication
`define SMDMC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smdmc check failed");

`endif

// ===== rtl/smdmc_pkg.sv =====
// Types and constants shared by the snooping MSI cache.
// No dependencies.
package smdmc_pkg;

   localparam int LINES     = 256;
   localparam int ADDR_BITS = 20;
   localparam int IDX_BITS  = $clog2(LINES);
   localparam int TAG_BITS  = ADDR_BITS - IDX_BITS;
   localparam int DATA_BITS = 32;
   localparam int CORE_BITS = 3;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_SNOOP = 2'd2;

   typedef enum logic [1:0] {
      ST_INVALID  = 2'd0,
      ST_SHARED   = 2'd1,
      ST_MODIFIED = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_BUSRD  = 2'd1,
      CMD_BUSRDX = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      state_type            state;
      logic [DATA_BITS-1:0] data;
   } line_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] write_data;
      cmd_type              snoop_cmd;
      logic [CORE_BITS-1:0] snoop_origin;
      logic [ADDR_BITS-1:0] snoop_address;
      logic [DATA_BITS-1:0] snoop_data;
      logic                 bus_grant;
      logic                 memory_busy;
   } item_type;

   typedef struct packed {
      logic                 read_pending;
      logic                 write_pending;
      logic [DATA_BITS-1:0] pend_word;
      logic [DATA_BITS-1:0] last_word;
      logic                 returned;
   } flags_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [ADDR_BITS-1:0] addr;
      logic [DATA_BITS-1:0] data;
   } bus_type;

   function automatic logic [IDX_BITS-1:0] line_index(input logic [ADDR_BITS-1:0] a);
      return a[IDX_BITS-1:0];
   endfunction

   function automatic logic [TAG_BITS-1:0] line_tag(input logic [ADDR_BITS-1:0] a);
      return a[ADDR_BITS-1:IDX_BITS];
   endfunction

endpackage

// ===== rtl/smdmc_line_ram.sv =====
// Line store: tag, state and data per line, one write and one registered read a cycle.
// Per-line valid bits give reset contents; write-to-read bypass. Uses smdmc_pkg.
module smdmc_line_ram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [smdmc_pkg::IDX_BITS-1:0]  rd_idx,
   input  logic                            wr_en,
   input  logic [smdmc_pkg::IDX_BITS-1:0]  wr_idx,
   input  smdmc_pkg::line_type             wr_line,
   output smdmc_pkg::line_type             rd_line
);
   import smdmc_pkg::*;

   line_type         line_mem [LINES];
   logic [LINES-1:0] vld_ff;
   line_type         rd_ff;
   line_type         byp_ff;
   logic             byp_sel_ff;
   logic             rd_vld_ff;
   logic             same_idx;

   assign same_idx = wr_en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_idx] <= wr_line;
      end
      if (rd_en) begin
         rd_ff  <= line_mem[rd_idx];
         byp_ff <= wr_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         byp_sel_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            byp_sel_ff <= same_idx;
            rd_vld_ff  <= same_idx || vld_ff[rd_idx];
         end
      end
   end

   always_comb begin
      if (!rd_vld_ff) begin
         rd_line = '{tag: '0, state: ST_INVALID, data: '0};
      end else if (byp_sel_ff) begin
         rd_line = byp_ff;
      end else begin
         rd_line = rd_ff;
      end
   end

endmodule

// ===== rtl/smdmc_coherence.sv =====
// MSI next-state logic for one core access or one snooped bus cycle.
// Purely combinational; uses smdmc_pkg.
module smdmc_coherence (
   input  smdmc_pkg::item_type                    item,
   input  smdmc_pkg::line_type                    cur_line,
   input  smdmc_pkg::flags_type                   flags,
   input  logic [smdmc_pkg::CORE_BITS-1:0]        core_id,
   output smdmc_pkg::line_type                    nxt_line,
   output smdmc_pkg::flags_type                   nxt_flags,
   output smdmc_pkg::bus_type                     bus
);
   import smdmc_pkg::*;

   logic                 is_wr;
   logic [ADDR_BITS-1:0] line_addr;
   logic [IDX_BITS-1:0]  idx;
   state_type            cur;
   logic                 hit;
   logic                 pend;
   logic                 other;

   assign is_wr     = (item.op == OP_WRITE);
   assign line_addr = (item.op == OP_SNOOP) ? item.snoop_address : item.address;
   assign idx       = line_index(line_addr);
   assign cur       = (cur_line.tag == line_tag(line_addr)) ? cur_line.state : ST_INVALID;
   assign hit       = is_wr ? (cur == ST_MODIFIED) : (cur != ST_INVALID);
   assign pend      = is_wr ? flags.write_pending : flags.read_pending;
   assign other     = (item.snoop_origin != core_id);

   always_comb begin
      nxt_line  = cur_line;
      nxt_flags = flags;
      bus       = '{cmd: CMD_NONE, addr: '0, data: '0};
      case (item.op)
         OP_READ, OP_WRITE: begin
            nxt_flags.pend_word = item.write_data;
            if (hit) begin
               if (is_wr) begin
                  nxt_line.data = item.write_data;
               end else begin
                  nxt_flags.last_word = cur_line.data;
               end
               nxt_flags.returned = 1'b1;
            end else begin
               nxt_flags.returned = 1'b0;
               if (!pend) begin
                  if (cur_line.state == ST_MODIFIED) begin
                     // victim write-back
                     if (item.bus_grant) begin
                        bus            = '{cmd: CMD_FLUSH, addr: {cur_line.tag, idx},
                                           data: cur_line.data};
                        nxt_line.state = ST_INVALID;
                     end
                  end else if (!item.memory_busy && item.bus_grant) begin
                     bus.cmd  = is_wr ? CMD_BUSRDX : CMD_BUSRD;
                     bus.addr = item.address;
                     if (is_wr) begin
                        nxt_flags.write_pending = 1'b1;
                     end else begin
                        nxt_flags.read_pending = 1'b1;
                     end
                  end
               end
            end
         end
         OP_SNOOP: begin
            case (item.snoop_cmd)
               CMD_BUSRD: begin
                  if (other && cur == ST_MODIFIED) begin
                     nxt_line.state = ST_SHARED;
                     if (item.bus_grant) begin
                        bus = '{cmd: CMD_FLUSH, addr: item.snoop_address,
                                data: cur_line.data};
                     end
                  end
               end
               CMD_BUSRDX: begin
                  if (other && cur != ST_INVALID) begin
                     if (cur == ST_MODIFIED && item.bus_grant) begin
                        bus = '{cmd: CMD_FLUSH, addr: item.snoop_address,
                                data: cur_line.data};
                     end
                     nxt_line.state = ST_INVALID;
                  end
               end
               CMD_FLUSH: begin
                  // completes a pending fill whatever its address
                  if (flags.read_pending) begin
                     nxt_line.data = item.snoop_data;
                     nxt_line.state = (cur == ST_MODIFIED) ? ST_MODIFIED : ST_SHARED;
                     nxt_line.tag = line_tag(item.snoop_address);
                     nxt_flags.read_pending = 1'b0;
                     nxt_flags.returned = 1'b1;
                     nxt_flags.last_word = item.snoop_data;
                  end else if (flags.write_pending) begin
                     nxt_line.data = flags.pend_word;
                     nxt_line.state = ST_MODIFIED;
                     nxt_line.tag = line_tag(item.snoop_address);
                     nxt_flags.write_pending = 1'b0;
                     nxt_flags.returned = 1'b1;
                  end else if (cur == ST_SHARED) begin
                     nxt_line.data = item.snoop_data;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/snooping_msi_direct_mapped_cache.sv =====
// Top level of the snooping MSI direct-mapped cache: input register, line store,
// coherence logic and result register. Uses smdmc_pkg, smdmc_line_ram, smdmc_coherence.
//
// One item (core read, core write or snooped bus cycle) is taken every clock unless
// req_stall is high; its result is registered onto the rsp_ channel once rsp_stall
// lets it leave the input register. The line store is read on acceptance and written
// back as the item leaves; a write-to-read bypass lets an item on the same line follow
// directly. Reset clears the line valid bits; with no clearing pass, items are taken
// immediately after reset. The user must write core_id through the csr_ channel only
// while the cache is idle; the block does not enforce it. csr_ready is always high.
`include "snooping_msi_direct_mapped_cache_assert.svh"

module snooping_msi_direct_mapped_cache (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smdmc_pkg::CORE_BITS-1:0]    csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic [smdmc_pkg::ADDR_BITS-1:0]    req_address,
   input  logic [smdmc_pkg::DATA_BITS-1:0]    req_write_data,
   input  logic [1:0]                         req_snoop_cmd,
   input  logic [smdmc_pkg::CORE_BITS-1:0]    req_snoop_origin,
   input  logic [smdmc_pkg::ADDR_BITS-1:0]    req_snoop_address,
   input  logic [smdmc_pkg::DATA_BITS-1:0]    req_snoop_data,
   input  logic                               req_bus_grant,
   input  logic                               req_memory_busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [smdmc_pkg::DATA_BITS-1:0]    rsp_read_data,
   output logic                               rsp_done_res,
   output logic [1:0]                         rsp_bus_req_cmd,
   output logic [smdmc_pkg::ADDR_BITS-1:0]    rsp_bus_req_addr,
   output logic [smdmc_pkg::DATA_BITS-1:0]    rsp_bus_req_data
);
   import smdmc_pkg::*;

   logic [CORE_BITS-1:0] core_id_ff;
   item_type             s1_ff;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   flags_type            flags_ff;
   flags_type            flags_in;
   bus_type              bus_ff;
   bus_type              bus_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;
   logic                 advance;
   item_type             req_item;
   logic [IDX_BITS-1:0]  rd_idx;
   logic [IDX_BITS-1:0]  s1_idx;
   line_type             cur_line;
   line_type             nxt_line;

   assign csr_ready = 1'b1;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign req_item = '{op: req_op, address: req_address, write_data: req_write_data,
                       snoop_cmd: cmd_type'(req_snoop_cmd),
                       snoop_origin: req_snoop_origin,
                       snoop_address: req_snoop_address, snoop_data: req_snoop_data,
                       bus_grant: req_bus_grant, memory_busy: req_memory_busy};

   assign rd_idx = line_index((req_op == OP_SNOOP) ? req_snoop_address : req_address);
   assign s1_idx = line_index((s1_ff.op == OP_SNOOP) ? s1_ff.snoop_address : s1_ff.address);

   smdmc_line_ram u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (rd_idx),
      .wr_en   (advance),
      .wr_idx  (s1_idx),
      .wr_line (nxt_line),
      .rd_line (cur_line)
   );

   smdmc_coherence u_coherence (
      .item      (s1_ff),
      .cur_line  (cur_line),
      .flags     (flags_ff),
      .core_id   (core_id_ff),
      .nxt_line  (nxt_line),
      .nxt_flags (flags_in),
      .bus       (bus_in)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_id_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '{read_pending: 1'b0, write_pending: 1'b0, pend_word: '0,
                           last_word: '0, returned: 1'b0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            core_id_ff <= csr_write_data;
         end
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_item;
      end
      if (advance) begin
         bus_ff <= bus_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = flags_ff.last_word;
   assign rsp_done_res     = flags_ff.returned;
   assign rsp_bus_req_cmd  = bus_ff.cmd;
   assign rsp_bus_req_addr = bus_ff.addr;
   assign rsp_bus_req_data = bus_ff.data;

   `SMDMC_ASSERT_NXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff)
   `SMDMC_ASSERT_NOW(a_idle_bus_quiet, clock, reset,
      rsp_valid_ff && bus_ff.cmd == CMD_NONE, bus_ff.addr == '0 && bus_ff.data == '0)
   `SMDMC_ASSERT_NOW(a_busrd_sets_pending, clock, reset,
      rsp_valid_ff && bus_ff.cmd == CMD_BUSRD, flags_ff.read_pending)
   `SMDMC_ASSERT_NOW(a_busrdx_sets_pending, clock, reset,
      rsp_valid_ff && bus_ff.cmd == CMD_BUSRDX, flags_ff.write_pending)

endmodule
